[rtl/core/hbmq_pkg.sv]
// shared types and constants for the hierarchical bitmap min queue
package hbmq_pkg;

  localparam int unsigned WORD_BITS = 32;
  localparam int unsigned IDX_BITS  = 5;

  typedef enum logic [1:0] {
    CMD_INSERT  = 2'd0,
    CMD_PEEK    = 2'd1,
    CMD_EXTRACT = 2'd2,
    CMD_CLEAR   = 2'd3
  } cmd_t;

  // tree levels, root first
  typedef enum logic [1:0] {
    LVL_TOP   = 2'd0,
    LVL_UPPER = 2'd1,
    LVL_MID   = 2'd2,
    LVL_LEAF  = 2'd3
  } lvl_t;

  typedef struct packed {
    logic [WORD_BITS-1:0] word;
    logic [IDX_BITS-1:0]  bit_idx;
  } wu_req_t;

  typedef struct packed {
    logic [IDX_BITS-1:0]  low_idx;
    logic                 is_zero;
    logic                 bit_val;
    logic [WORD_BITS-1:0] set_word;
    logic [WORD_BITS-1:0] clr_word;
    logic                 clr_zero;
  } wu_res_t;

  typedef struct packed {
    logic rd_en;
    logic wr_en;
    lvl_t lvl;
  } st_ctrl_t;

endpackage

[rtl/core/hbmq_word_unit.sv]
// shared word unit: lowest set bit, bit test, bit set and bit clear on one 32-bit word
module hbmq_word_unit (
  input  hbmq_pkg::wu_req_t req,
  output hbmq_pkg::wu_res_t res
);
  import hbmq_pkg::*;

  logic [WORD_BITS-1:0] one_hot;
  logic [IDX_BITS-1:0]  low;

  // priority pick, lowest set bit wins
  always_comb begin
    low = '0;
    for (int i = WORD_BITS - 1; i >= 0; i--) begin
      if (req.word[i]) begin
        low = IDX_BITS'(i);
      end
    end
  end

  assign one_hot      = WORD_BITS'(1) << req.bit_idx;
  assign res.low_idx  = low;
  assign res.is_zero  = (req.word == '0);
  assign res.bit_val  = req.word[req.bit_idx];
  assign res.set_word = req.word | one_hot;
  assign res.clr_word = req.word & ~one_hot;
  assign res.clr_zero = ((req.word & ~one_hot) == '0);

endmodule

[rtl/core/hbmq_store.sv]
// leaf, mid and upper bitmap memories behind one shared read and write port
module hbmq_store #(
  parameter int KEY_BITS = 17
) (
  input  logic                 clk,
  input  hbmq_pkg::st_ctrl_t   ctrl,
  input  logic [KEY_BITS-6:0]  addr,
  input  logic [31:0]          wdata,
  output logic [31:0]          rdata
);
  import hbmq_pkg::*;

  localparam int LA          = KEY_BITS - 5;
  localparam int MA          = KEY_BITS - 10;
  localparam int UA          = KEY_BITS - 15;
  localparam int LEAF_DEPTH  = 1 << LA;
  localparam int MID_DEPTH   = 1 << MA;
  localparam int UPPER_DEPTH = 1 << UA;

  logic [WORD_BITS-1:0] leaf_mem  [LEAF_DEPTH];
  logic [WORD_BITS-1:0] mid_mem   [MID_DEPTH];
  logic [WORD_BITS-1:0] upper_mem [UPPER_DEPTH];

  logic [WORD_BITS-1:0] leaf_rd_r;
  logic [WORD_BITS-1:0] mid_rd_r;
  logic [WORD_BITS-1:0] upper_rd_r;
  lvl_t                 rd_lvl_r;

  logic [LA-1:0] leaf_addr;
  logic [MA-1:0] mid_addr;
  logic [UA-1:0] upper_addr;

  assign leaf_addr  = addr;
  assign mid_addr   = addr[LA-1:5];
  assign upper_addr = addr[LA-1:10];

  always_ff @(posedge clk) begin
    if (ctrl.wr_en && ctrl.lvl == LVL_LEAF) begin
      leaf_mem[leaf_addr] <= wdata;
    end
    if (ctrl.rd_en && ctrl.lvl == LVL_LEAF) begin
      leaf_rd_r <= leaf_mem[leaf_addr];
    end
  end

  always_ff @(posedge clk) begin
    if (ctrl.wr_en && ctrl.lvl == LVL_MID) begin
      mid_mem[mid_addr] <= wdata;
    end
    if (ctrl.rd_en && ctrl.lvl == LVL_MID) begin
      mid_rd_r <= mid_mem[mid_addr];
    end
  end

  always_ff @(posedge clk) begin
    if (ctrl.wr_en && ctrl.lvl == LVL_UPPER) begin
      upper_mem[upper_addr] <= wdata;
    end
    if (ctrl.rd_en && ctrl.lvl == LVL_UPPER) begin
      upper_rd_r <= upper_mem[upper_addr];
    end
  end

  always_ff @(posedge clk) begin
    if (ctrl.rd_en) begin
      rd_lvl_r <= ctrl.lvl;
    end
  end

  always_comb begin
    case (rd_lvl_r)
      LVL_LEAF:  rdata = leaf_rd_r;
      LVL_MID:   rdata = mid_rd_r;
      LVL_UPPER: rdata = upper_rd_r;
      default:   rdata = '0;
    endcase
  end

endmodule

[rtl/core/hierarchical_bitmap_min_queue.sv]
// hierarchical bitmap min queue: four-level 32-ary occupancy tree over KEY_BITS-bit keys
//
// Input channel in_valid/in_stall carries a request of in_command and in_key:
// insert a key, peek the minimum, extract the minimum, or clear all. Every
// request gives exactly one result on out_valid/out_stall with out_min_key
// and out_was_empty (key is 0 for insert and clear, and for an empty set).
// One request is in flight at a time; in_stall is high while it is worked.
// Clear goes straight to the result; a peek or extract on an empty set stops
// at the top word; insert and peek walk every level; extract also clears the
// found bit, walking up while words empty. The next request is taken in the
// cycle after the result is loaded. The tree walk reads each level through a
// single memory port and one shared word unit (lowest set bit, bit set, bit clear).
// The result sits in an output register; a stalled result holds and the
// block may already accept and work the next request, which then waits to
// load its result until the register is taken.
// Reset, and the clear request, zero only the top word; a lower word counts
// as empty unless its parent bit is set, so the memories need no clearing
// pass.
module hierarchical_bitmap_min_queue #(
  parameter int KEY_BITS = 17
) (
  input  logic                clk,
  input  logic                rst_n,
  input  logic                in_valid,
  output logic                in_stall,
  input  logic [1:0]          in_command,
  input  logic [KEY_BITS-1:0] in_key,
  output logic                out_valid,
  input  logic                out_stall,
  output logic [KEY_BITS-1:0] out_min_key,
  output logic                out_was_empty
);
  import hbmq_pkg::*;

  localparam int UA = KEY_BITS - 15;
  localparam int TN = 1 << UA;

  typedef enum logic [5:0] {
    S_IDLE = 6'b000001,
    S_TOP  = 6'b000010,
    S_RD   = 6'b000100,
    S_PROC = 6'b001000,
    S_DEL  = 6'b010000,
    S_DONE = 6'b100000
  } state_t;

  state_t                state_r, state_nxt;
  cmd_t                  cmd_r, cmd_nxt;
  logic [KEY_BITS-1:0]   key_r, key_nxt;
  lvl_t                  lvl_r, lvl_nxt;
  logic                  parent_ok_r, parent_ok_nxt;
  logic                  empty_r, empty_nxt;
  logic [TN-1:0]         top_r, top_nxt;
  logic [WORD_BITS-1:0]  upper_w_r, upper_w_nxt;
  logic [WORD_BITS-1:0]  mid_w_r, mid_w_nxt;
  logic [WORD_BITS-1:0]  leaf_w_r, leaf_w_nxt;
  logic                  out_valid_r, out_valid_nxt;
  logic [KEY_BITS-1:0]   out_min_key_r, out_min_key_nxt;
  logic                  out_was_empty_r, out_was_empty_nxt;

  wu_req_t               wu_req;
  wu_res_t               wu_res;
  st_ctrl_t              st_ctrl;
  logic [WORD_BITS-1:0]  st_rdata;
  logic [WORD_BITS-1:0]  st_wdata;
  logic [IDX_BITS-1:0]   lvl_bit;
  logic [WORD_BITS-1:0]  stash_word;
  logic                  in_acc;
  logic                  slot_free;
  logic                  is_find;

  hbmq_word_unit u_word_unit (
    .req (wu_req),
    .res (wu_res)
  );

  hbmq_store #(.KEY_BITS(KEY_BITS)) u_store (
    .clk   (clk),
    .ctrl  (st_ctrl),
    .addr  (key_r[KEY_BITS-1:5]),
    .wdata (st_wdata),
    .rdata (st_rdata)
  );

  assign in_stall      = (state_r != S_IDLE);
  assign in_acc        = in_valid && !in_stall;
  assign slot_free     = !out_valid_r || !out_stall;
  assign is_find       = (cmd_r == CMD_PEEK) || (cmd_r == CMD_EXTRACT);
  assign out_valid     = out_valid_r;
  assign out_min_key   = out_min_key_r;
  assign out_was_empty = out_was_empty_r;

  // key bits that index the word at the current level
  always_comb begin
    case (lvl_r)
      LVL_TOP:   lvl_bit = IDX_BITS'(key_r[KEY_BITS-1:15]);
      LVL_UPPER: lvl_bit = key_r[14:10];
      LVL_MID:   lvl_bit = key_r[9:5];
      LVL_LEAF:  lvl_bit = key_r[4:0];
      default:   lvl_bit = '0;
    endcase
  end

  always_comb begin
    case (lvl_r)
      LVL_UPPER: stash_word = upper_w_r;
      LVL_MID:   stash_word = mid_w_r;
      LVL_LEAF:  stash_word = leaf_w_r;
      default:   stash_word = WORD_BITS'(top_r);
    endcase
  end

  always_comb begin
    wu_req.bit_idx = lvl_bit;
    case (state_r)
      S_TOP:   wu_req.word = WORD_BITS'(top_r);
      S_PROC:  wu_req.word = parent_ok_r ? st_rdata : '0;
      S_DEL:   wu_req.word = stash_word;
      default: wu_req.word = '0;
    endcase
  end

  always_comb begin
    state_nxt         = state_r;
    cmd_nxt           = cmd_r;
    key_nxt           = key_r;
    lvl_nxt           = lvl_r;
    parent_ok_nxt     = parent_ok_r;
    empty_nxt         = empty_r;
    top_nxt           = top_r;
    upper_w_nxt       = upper_w_r;
    mid_w_nxt         = mid_w_r;
    leaf_w_nxt        = leaf_w_r;
    out_valid_nxt     = out_valid_r && out_stall;
    out_min_key_nxt   = out_min_key_r;
    out_was_empty_nxt = out_was_empty_r;
    st_ctrl.rd_en     = 1'b0;
    st_ctrl.wr_en     = 1'b0;
    st_ctrl.lvl       = lvl_r;
    st_wdata          = wu_res.set_word;

    case (state_r)
      S_IDLE: begin
        if (in_acc) begin
          cmd_nxt   = cmd_t'(in_command);
          empty_nxt = 1'b0;
          lvl_nxt   = LVL_TOP;
          if (cmd_t'(in_command) == CMD_INSERT) begin
            key_nxt   = in_key;
            state_nxt = S_TOP;
          end else if (cmd_t'(in_command) == CMD_CLEAR) begin
            top_nxt   = '0;
            state_nxt = S_DONE;
          end else begin
            key_nxt   = '0;
            state_nxt = S_TOP;
          end
        end
      end

      S_TOP: begin
        lvl_nxt = LVL_UPPER;
        if (!is_find) begin
          parent_ok_nxt = wu_res.bit_val;
          top_nxt       = wu_res.set_word[TN-1:0];
          state_nxt     = S_RD;
        end else if (wu_res.is_zero) begin
          empty_nxt = 1'b1;
          state_nxt = S_DONE;
        end else begin
          key_nxt[KEY_BITS-1:15] = wu_res.low_idx[UA-1:0];
          parent_ok_nxt          = 1'b1;
          state_nxt              = S_RD;
        end
      end

      S_RD: begin
        st_ctrl.rd_en = 1'b1;
        state_nxt     = S_PROC;
      end

      S_PROC: begin
        if (!is_find) begin
          st_ctrl.wr_en = 1'b1;
          parent_ok_nxt = wu_res.bit_val;
        end else begin
          case (lvl_r)
            LVL_UPPER: begin
              key_nxt[14:10] = wu_res.low_idx;
              upper_w_nxt    = wu_req.word;
            end
            LVL_MID: begin
              key_nxt[9:5] = wu_res.low_idx;
              mid_w_nxt    = wu_req.word;
            end
            LVL_LEAF: begin
              key_nxt[4:0] = wu_res.low_idx;
              leaf_w_nxt   = wu_req.word;
            end
            default: begin
              key_nxt = key_r;
            end
          endcase
        end
        if (lvl_r == LVL_LEAF) begin
          state_nxt = (cmd_r == CMD_EXTRACT) ? S_DEL : S_DONE;
        end else begin
          lvl_nxt   = lvl_t'(lvl_r + 2'd1);
          state_nxt = S_RD;
        end
      end

      // clear the found bit, walking up while words empty
      S_DEL: begin
        st_wdata = wu_res.clr_word;
        if (lvl_r == LVL_TOP) begin
          top_nxt   = wu_res.clr_word[TN-1:0];
          state_nxt = S_DONE;
        end else begin
          st_ctrl.wr_en = 1'b1;
          if (wu_res.clr_zero) begin
            lvl_nxt = lvl_t'(lvl_r - 2'd1);
          end else begin
            state_nxt = S_DONE;
          end
        end
      end

      S_DONE: begin
        if (slot_free) begin
          out_valid_nxt     = 1'b1;
          out_min_key_nxt   = (is_find && !empty_r) ? key_r : '0;
          out_was_empty_nxt = is_find && empty_r;
          state_nxt         = S_IDLE;
        end
      end

      default: begin
        state_nxt = S_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= S_IDLE;
      top_r       <= '0;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      top_r       <= top_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    cmd_r           <= cmd_nxt;
    key_r           <= key_nxt;
    lvl_r           <= lvl_nxt;
    parent_ok_r     <= parent_ok_nxt;
    empty_r         <= empty_nxt;
    upper_w_r       <= upper_w_nxt;
    mid_w_r         <= mid_w_nxt;
    leaf_w_r        <= leaf_w_nxt;
    out_min_key_r   <= out_min_key_nxt;
    out_was_empty_r <= out_was_empty_nxt;
  end

endmodule

[rtl/core/hbmq_checker.sv]
// port-level checks for the hierarchical bitmap min queue, bound to the top level
module hbmq_checker #(
  parameter int KEY_BITS = 17
) (
  input logic                clk,
  input logic                rst_n,
  input logic                in_valid,
  input logic                in_stall,
  input logic [1:0]          in_command,
  input logic                out_valid,
  input logic                out_stall,
  input logic [KEY_BITS-1:0] out_min_key,
  input logic                out_was_empty
);
  import hbmq_pkg::*;

  // a held result does not move
  assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_stall |=> out_valid && $stable(out_min_key) && $stable(out_was_empty))
    else $error("stalled result changed");

  // an empty report never carries a key
  assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_was_empty |-> out_min_key == '0)
    else $error("empty result with non-zero key");

  // one request at a time: after an accept the input side stalls
  assert property (@(posedge clk) disable iff (!rst_n)
    in_valid && !in_stall |=> in_stall)
    else $error("second request taken while one is in flight");

  // a clear reports neither a key nor empty, unless a stalled result held it back
  assert property (@(posedge clk) disable iff (!rst_n)
    in_valid && !in_stall && (in_command == CMD_CLEAR) |=> ##1
      out_valid && !out_was_empty && out_min_key == '0 || $past(out_stall))
    else $error("clear result not clean");

  // reset leaves the block idle with no result
  assert property (@(posedge clk) !rst_n |=> !out_valid && !in_stall)
    else $error("not idle after reset");

endmodule

bind hierarchical_bitmap_min_queue hbmq_checker #(.KEY_BITS(KEY_BITS)) u_hbmq_checker (.*);
